FILE: hw/rtl/prsd_pkg.sv
// ----------------------------------------------------------------------------
// prsd_pkg
// Shared types and constants for the palette run-length sprite decoder.
// ----------------------------------------------------------------------------
package prsd_pkg;

  localparam int PaletteDepthDefault = 256;

  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_DATA    = 2'd1;
  localparam logic [1:0] OP_PALETTE = 2'd2;

  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;
  localparam logic [1:0] CFG_PSIZE  = 2'd3;

  localparam logic [1:0] ST_BUSY      = 2'd0;
  localparam logic [1:0] ST_COMPLETE  = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;

  localparam logic [1:0] PH_ROW  = 2'd0;
  localparam logic [1:0] PH_TOK  = 2'd1;
  localparam logic [1:0] PH_RUN  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;
  } in_item_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [1:0]  status;
  } out_item_t;

  // classified work passed from the parser to the pixel stage
  typedef struct packed {
    logic        lookup;
    logic        direct;
    logic        pal_write;
    logic [7:0]  index;
    logic [23:0] color;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  alpha;
    logic [1:0]  status;
  } job_t;

  // alpha code expansion
  function automatic logic [7:0] alpha_scale(input logic [7:0] code);
    logic [10:0] p;
    p = {8'd0, code[7:5]} * 11'd255;
    if (code == 8'hff) return 8'hff;
    return p[10:3];
  endfunction

endpackage

FILE: hw/rtl/prsd_front.sv
// ----------------------------------------------------------------------------
// prsd_front
// Parses the byte stream, tracks position and emits one job per item.
// ----------------------------------------------------------------------------
module prsd_front #(
  parameter int PaletteDepth = prsd_pkg::PaletteDepthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  prsd_pkg::in_item_t in_data,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output prsd_pkg::job_t    job,
  output logic              job_valid,
  input  logic              job_room
);
  import prsd_pkg::*;

  logic        take;
  logic [1:0]  decode_mode;
  logic [15:0] image_width, image_height;
  logic [8:0]  palette_size;
  logic [15:0] row_count, row_count_next;
  logic [16:0] column_count, column_count_next;
  logic [7:0]  runs_left, runs_left_next;
  logic [6:0]  run_pixels_left, run_pixels_left_next;
  logic [1:0]  run_kind, run_kind_next;
  logic [1:0]  byte_phase, byte_phase_next;
  logic [23:0] held_bytes, held_bytes_next;
  logic [1:0]  parse_phase, parse_phase_next;
  logic        sprite_done, sprite_done_next, excess_seen, excess_seen_next;
  logic [8:0]  limit;
  job_t        j;
  logic [6:0]  len;
  logic [1:0]  kind;
  logic [7:0]  b, rl;
  logic [15:0] rc1;

  assign take = in_valid && job_room;
  assign limit = (palette_size < 9'(PaletteDepth)) ? palette_size : 9'(PaletteDepth);
  assign b = in_data.data_byte;

  // parser next state
  always_comb begin
    row_count_next = row_count; column_count_next = column_count;
    runs_left_next = runs_left; run_pixels_left_next = run_pixels_left;
    run_kind_next = run_kind; byte_phase_next = byte_phase;
    held_bytes_next = held_bytes; parse_phase_next = parse_phase;
    sprite_done_next = sprite_done; excess_seen_next = excess_seen;
    j = '0; len = '0; kind = '0; rl = '0;
    rc1 = row_count + 16'd1;
    j.x = column_count[15:0];
    j.y = row_count;
    unique case (in_data.opcode)
      OP_START: begin
        row_count_next = '0; column_count_next = '0; runs_left_next = '0;
        run_pixels_left_next = '0; run_kind_next = '0; byte_phase_next = '0;
        held_bytes_next = '0; sprite_done_next = 1'b0; excess_seen_next = 1'b0;
        parse_phase_next = (image_height == 16'd0 ||
                            (!decode_mode[1] && image_width == 16'd0)) ? PH_DONE : PH_ROW;
      end
      OP_PALETTE: begin
        j.pal_write = 32'(in_data.palette_index) < PaletteDepth;
        j.index = in_data.palette_index;
        j.color = in_data.palette_color;
      end
      OP_DATA: if (!sprite_done) begin
        if (parse_phase == PH_DONE) begin
          if (decode_mode == 2'd0) excess_seen_next = 1'b1;
        end else if (decode_mode == 2'd0) begin
          if (byte_phase < 2'd3) begin
            held_bytes_next = held_bytes | (24'(b) << {byte_phase, 3'b000});
            byte_phase_next = byte_phase + 2'd1;
          end else begin
            // held bytes are blue, green, red from low to high
            j.direct = 1'b1;
            j.color = held_bytes;
            j.alpha = b;
            byte_phase_next = '0; held_bytes_next = '0;
            column_count_next = column_count + 17'd1;
            if (column_count_next >= {1'b0, image_width}) begin
              row_count_next = rc1; column_count_next = '0;
              parse_phase_next = (rc1 >= image_height) ? PH_DONE : PH_ROW;
            end
          end
        end else if (decode_mode == 2'd1) begin
          if (byte_phase == 2'd0) begin
            held_bytes_next = {16'd0, b}; byte_phase_next = 2'd1;
          end else begin
            j.lookup = b != 8'd0 && column_count < {1'b0, image_width} &&
                       {1'b0, held_bytes[7:0]} < limit;
            j.index = held_bytes[7:0]; j.alpha = b;
            byte_phase_next = '0; held_bytes_next = '0;
            column_count_next = column_count + 17'd1;
            if (column_count_next >= {1'b0, image_width}) begin
              row_count_next = rc1; column_count_next = '0;
              parse_phase_next = (rc1 >= image_height) ? PH_DONE : PH_ROW;
            end
          end
        end else begin
          // run-length modes
          rl = runs_left;
          unique case (parse_phase)
            PH_ROW: begin
              runs_left_next = b; column_count_next = '0;
              if (b == 8'd0) begin
                row_count_next = rc1;
                parse_phase_next = (rc1 >= image_height) ? PH_DONE : PH_ROW;
              end else parse_phase_next = PH_TOK;
            end
            PH_TOK: begin
              if (decode_mode == 2'd2) begin
                len = b[6:0]; kind = b[7] ? 2'd3 : 2'd0;
              end else begin
                len = {1'b0, b[5:0]}; kind = b[7:6];
                if (kind == 2'd2) kind = 2'd1;
              end
              run_kind_next = kind;
              if (kind == 2'd3 || len == 7'd0) begin
                if (kind == 2'd3) column_count_next = column_count + 17'(len);
                rl = runs_left - 8'd1;
              end else begin
                run_pixels_left_next = len; byte_phase_next = '0;
                parse_phase_next = PH_RUN;
              end
            end
            default: begin
              if (run_kind == 2'd1 && byte_phase == 2'd0) begin
                held_bytes_next = {16'd0, b}; byte_phase_next = 2'd1;
              end else begin
                j.index = b;
                j.lookup = column_count < {1'b0, image_width} && {1'b0, b} < limit;
                if (run_kind == 2'd1) begin
                  if (held_bytes[7:0] < 8'h20) j.lookup = 1'b0;
                  j.alpha = alpha_scale(held_bytes[7:0]);
                end else j.alpha = 8'hff;
                byte_phase_next = '0; held_bytes_next = '0;
                column_count_next = column_count + 17'd1;
                if (run_pixels_left <= 7'd1) begin
                  run_pixels_left_next = '0;
                  rl = runs_left - 8'd1;
                end else run_pixels_left_next = run_pixels_left - 7'd1;
              end
            end
          endcase
          // end of run bookkeeping
          if (rl != runs_left) begin
            runs_left_next = rl;
            if (rl == 8'd0) begin
              row_count_next = rc1; column_count_next = '0;
              parse_phase_next = (rc1 >= image_height) ? PH_DONE : PH_ROW;
            end else parse_phase_next = PH_TOK;
          end
        end
        if (in_data.last_byte) begin
          sprite_done_next = 1'b1;
          j.status = (parse_phase_next == PH_DONE && !excess_seen_next) ?
                     ST_COMPLETE : ST_MALFORMED;
        end
      end
      default: ;
    endcase
    if (!j.lookup && !j.direct) begin
      j.x = '0; j.y = '0; j.alpha = '0;
      if (!j.pal_write) begin j.index = '0; j.color = '0; end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= '0; image_width <= 16'd1; image_height <= 16'd1;
      palette_size <= '0; row_count <= '0; column_count <= '0; runs_left <= '0;
      run_pixels_left <= '0; run_kind <= '0; byte_phase <= '0; held_bytes <= '0;
      parse_phase <= PH_ROW; sprite_done <= 1'b0; excess_seen <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MODE:   decode_mode <= cfg_data[1:0];
          CFG_WIDTH:  image_width <= cfg_data;
          CFG_HEIGHT: image_height <= cfg_data;
          CFG_PSIZE:  palette_size <= cfg_data[8:0];
          default: ;
        endcase
      end
      job_valid <= take;
      if (take) begin
        row_count <= row_count_next; column_count <= column_count_next;
        runs_left <= runs_left_next; run_pixels_left <= run_pixels_left_next;
        run_kind <= run_kind_next; byte_phase <= byte_phase_next;
        held_bytes <= held_bytes_next; parse_phase <= parse_phase_next;
        sprite_done <= sprite_done_next; excess_seen <= excess_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) job <= j;
  end

endmodule

FILE: hw/rtl/prsd_back.sv
// ----------------------------------------------------------------------------
// prsd_back
// Palette memory, result queue and output stage.
// ----------------------------------------------------------------------------
module prsd_back #(
  parameter int PaletteDepth = prsd_pkg::PaletteDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  prsd_pkg::job_t     job,
  input  logic               job_valid,
  output logic               job_room,
  output prsd_pkg::out_item_t out_data,
  output logic               out_valid,
  input  logic               out_stall
);
  import prsd_pkg::*;

  localparam int AW = (PaletteDepth > 1) ? $clog2(PaletteDepth) : 1;

  logic [23:0] pal_mem [PaletteDepth];
  logic [23:0] rd_color;
  job_t        s2;
  logic        s2_valid;
  out_item_t   r, q [4];
  logic [2:0]  count;
  logic [1:0]  wr_ptr, rd_ptr;
  logic        push, pop;

  // palette write and registered read
  always_ff @(posedge clk) begin
    if (job_valid && job.pal_write) pal_mem[job.index[AW-1:0]] <= job.color;
    rd_color <= pal_mem[job.index[AW-1:0]];
    s2 <= job;
  end

  // format result from the lookup stage
  always_comb begin
    r = '0;
    r.status = s2.status;
    if (s2.lookup || s2.direct) begin
      r.pixel_valid = 1'b1;
      r.pixel_x = s2.x; r.pixel_y = s2.y; r.alpha = s2.alpha;
      {r.red, r.green, r.blue} = s2.direct ? s2.color : rd_color;
    end
  end

  // in-flight items plus queued results must fit in four slots
  assign job_room = ({1'b0, count} + 3'(job_valid) + 3'(s2_valid)) <= 4'd3 ||
                    pop && ({1'b0, count} + 3'(job_valid) + 3'(s2_valid)) <= 4'd4;
  assign push = s2_valid;
  assign pop = out_valid && !out_stall;
  assign out_valid = count != 3'd0;
  assign out_data = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0; count <= '0; wr_ptr <= '0; rd_ptr <= '0;
    end else begin
      s2_valid <= job_valid;
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule

FILE: hw/rtl/palette_rle_sprite_decoder.sv
// ----------------------------------------------------------------------------
// palette_rle_sprite_decoder
// Decodes direct, indexed and run-length sprite bytes into RGBA pixel writes.
// ----------------------------------------------------------------------------
// usage:
// - in channel: one beat per byte item (start, data byte, palette write),
//   taken when in_valid is high and in_stall low
// - out channel: one result beat per accepted item, in order; pixel_valid
//   marks a real pixel write, status reports completion on the last byte
// - cfg channel: cfg_index selects mode, width, height or palette size;
//   cfg_ready is always high, write only while idle
// - the parse, palette read and queue registers lie between input beat and
//   output beat; throughput one item per cycle while in_stall is low
// - a four-entry result queue absorbs a stalled receiver; in_stall rises
//   once the queue plus in-flight beats would overflow it
// - synchronous reset clears position state and config to defaults; the
//   palette memory holds garbage until written
// ----------------------------------------------------------------------------
module palette_rle_sprite_decoder #(
  parameter int PaletteDepth = prsd_pkg::PaletteDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  prsd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output prsd_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import prsd_pkg::*;

  job_t job;
  logic job_valid, job_room;

  assign cfg_ready = 1'b1;
  assign in_stall = !job_room;

  prsd_front #(.PaletteDepth(PaletteDepth)) u_front (
    .clk, .rst, .in_valid, .in_data,
    .cfg_valid, .cfg_index, .cfg_data,
    .job, .job_valid, .job_room
  );

  prsd_back #(.PaletteDepth(PaletteDepth)) u_back (
    .clk, .rst, .job, .job_valid, .job_room,
    .out_data, .out_valid, .out_stall
  );

endmodule
